@@ hw/rtl/tracker_pattern_unpacker_defines.svh @@
// Assertion macros for the checker file of the pattern unpacker.
// Depends on nothing; every macro expects clk and rst_n in scope.
`ifndef TRACKER_PATTERN_UNPACKER_DEFINES_SVH
`define TRACKER_PATTERN_UNPACKER_DEFINES_SVH

// General property, sampled on clk, off while reset is asserted.
`define TPU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A stalled channel keeps the given condition in the next cycle.
`define TPU_ASSERT_STALL(label, vld, rdy, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> (cond)) else $error(msg);

`endif

@@ hw/rtl/tpu_pkg.sv @@
// Package for the pattern unpacker: payload structs, parser phases, effect codes
// and the note / effect translation functions. Depends on nothing.
package tpu_pkg;

    localparam int unsigned CfgIndexWidth = 1;
    localparam int unsigned CfgDataWidth  = 8;

    localparam logic [CfgIndexWidth-1:0] CFG_CHANNEL_COUNT = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CFG_LONG_NAMES    = 1'b1;

    localparam logic [7:0] CHANNEL_COUNT_RESET = 8'd4;
    localparam logic [3:0] HDR_LEN_SHORT       = 4'd8;
    localparam logic [3:0] HDR_LEN_LONG        = 4'd12;

    // raw effect codes
    localparam logic [7:0] FXI_SLIDE_A   = 8'h01;
    localparam logic [7:0] FXI_VSLIDE_UP = 8'h02;
    localparam logic [7:0] FXI_SLIDE_B   = 8'h03;
    localparam logic [7:0] FXI_VSLIDE_DN = 8'h04;
    localparam logic [7:0] FXI_PORTA_UP  = 8'h0C;
    localparam logic [7:0] FXI_PORTA_DN  = 8'h0E;
    localparam logic [7:0] FXI_TONEPORTA = 8'h0F;
    localparam logic [7:0] FXI_VIBRATO   = 8'h15;
    localparam logic [7:0] FXI_EXT_9     = 8'h2A;
    localparam logic [7:0] FXI_LONG      = 8'h29;
    localparam logic [7:0] FXI_JUMP      = 8'h33;
    localparam logic [7:0] FXI_BREAK     = 8'h34;
    localparam logic [7:0] FXI_TEMPO_A   = 8'h3D;
    localparam logic [7:0] FXI_TEMPO_B   = 8'h3E;
    localparam logic [7:0] FXI_NOTE_BASE = 8'h40;

    // translated effect codes
    localparam logic [7:0] FXO_NONE      = 8'd0;
    localparam logic [7:0] FXO_PORTA_UP  = 8'd1;
    localparam logic [7:0] FXO_PORTA_DN  = 8'd2;
    localparam logic [7:0] FXO_TONEPORTA = 8'd3;
    localparam logic [7:0] FXO_VIBRATO   = 8'd4;
    localparam logic [7:0] FXO_VOLSLIDE  = 8'd10;
    localparam logic [7:0] FXO_JUMP      = 8'd11;
    localparam logic [7:0] FXO_BREAK     = 8'd13;
    localparam logic [7:0] FXO_EXTENDED  = 8'd14;
    localparam logic [7:0] FXO_TEMPO     = 8'd15;

    localparam logic [3:0] EXT_RETRIG = 4'h9;
    localparam logic [3:0] EXT_FINE_A = 4'hA;
    localparam logic [3:0] EXT_FINE_B = 4'hB;

    typedef enum logic [3:0] {
        PH_HDR     = 4'd0,
        PH_ROWS_LO = 4'd1,
        PH_ROWS_HI = 4'd2,
        PH_LEN_LO  = 4'd3,
        PH_LEN_HI  = 4'd4,
        PH_FLAG    = 4'd5,
        PH_CHAN    = 4'd6,
        PH_NOTE    = 4'd7,
        PH_INS     = 4'd8,
        PH_VOL     = 4'd9,
        PH_FXT     = 4'd10,
        PH_FXP     = 4'd11,
        PH_SKIP1   = 4'd12,
        PH_SKIP2   = 4'd13,
        PH_IDLE    = 4'd14
    } phase_t;

    typedef struct packed {
        logic [7:0] chunk_byte;
        logic       chunk_start;
    } in_item_t;

    typedef struct packed {
        logic [15:0] row_index;
        logic [7:0]  channel_index;
        logic [3:0]  field_mask;
        logic [7:0]  note_value;
        logic [7:0]  instrument_value;
        logic [6:0]  volume_value;
        logic [7:0]  effect_type;
        logic [7:0]  effect_param;
        logic        pattern_done;
    } out_item_t;

    typedef struct packed {
        logic [7:0] channel_count;
        logic       long_names;
    } cfg_t;

    // parser -> result register
    typedef struct packed {
        logic      emit;
        out_item_t item;
    } result_t;

    typedef struct packed {
        logic       set_note;
        logic [7:0] note;
        logic [7:0] etype;
        logic [7:0] eparam;
    } fx_t;

    function automatic logic [7:0] note_of(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        return 8'(hi * 8'd12 + {4'b0, b[3:0]} + 8'd2);
    endfunction

    function automatic fx_t translate(input logic [7:0] t, input logic [7:0] p);
        fx_t        r;
        logic [7:0] pm1;
        logic [7:0] pp1;
        pm1 = p - 8'd1;
        pp1 = p + 8'd1;
        r.set_note = 1'b0;
        r.note     = note_of(t);
        r.etype    = t;
        r.eparam   = p;
        if (t >= FXI_NOTE_BASE) begin
            if (p[7:4] == 4'd0) begin
                r.set_note = 1'b1;
                r.etype    = FXO_TONEPORTA;
                r.eparam   = {pp1[6:0], 1'b0};
            end
        end
        else begin
            case (t)
                FXI_SLIDE_A:
                begin
                    r.etype  = FXO_EXTENDED;
                    r.eparam = {EXT_FINE_A, p[4:1]};
                end
                FXI_VSLIDE_UP:
                begin
                    r.etype  = FXO_VOLSLIDE;
                    r.eparam = {p[4:1], 4'b0};
                end
                FXI_SLIDE_B:
                begin
                    r.etype  = FXO_EXTENDED;
                    r.eparam = {EXT_FINE_B, p[4:1]};
                end
                FXI_VSLIDE_DN:
                begin
                    r.etype  = FXO_VOLSLIDE;
                    r.eparam = {1'b0, p[7:1]};
                end
                FXI_PORTA_UP:
                begin
                    r.etype  = FXO_PORTA_UP;
                    r.eparam = (p == 8'd0) ? 8'd0 : {1'b0, pm1[7:1]};
                end
                FXI_PORTA_DN:
                begin
                    r.etype  = FXO_PORTA_DN;
                    r.eparam = (p == 8'd0) ? 8'd0 : {1'b0, pm1[7:1]};
                end
                FXI_TONEPORTA:
                begin
                    r.etype  = FXO_TONEPORTA;
                    r.eparam = {2'b0, p[7:2]};
                end
                FXI_VIBRATO:   r.etype = FXO_VIBRATO;
                FXI_EXT_9:
                begin
                    r.etype  = FXO_EXTENDED;
                    r.eparam = {EXT_RETRIG, p[3:0]};
                end
                FXI_LONG:      r.etype = FXI_LONG;
                FXI_JUMP:      r.etype = FXO_JUMP;
                FXI_BREAK:     r.etype = FXO_BREAK;
                FXI_TEMPO_A:   r.etype = FXO_TEMPO;
                FXI_TEMPO_B:   r.etype = FXO_TEMPO;
                default:
                begin
                    r.etype  = FXO_NONE;
                    r.eparam = 8'd0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/tracker_pattern_unpacker.sv @@
// Top level of the pattern unpacker: input register, config registers, parser and
// result register. Depends on tpu_pkg, tpu_parser and tpu_out_reg.
//
// Takes a packed pattern chunk one byte per transaction and returns at most one
// event per byte. Sustained rate is one byte per clock; a byte is accepted into the
// input register, and the combinational parser step loads its result into the
// result register. Input stalls only while the result register is full and not
// being taken.
// Configuration writes are to be made while no bytes are in flight.
module tracker_pattern_unpacker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tpu_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tpu_pkg::out_item_t                  out_data,
    input  logic                                cfg_write,
    input  logic [tpu_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [tpu_pkg::CfgDataWidth-1:0]    cfg_data
);

    logic              in_valid_reg;
    tpu_pkg::in_item_t in_data_reg;
    tpu_pkg::cfg_t     cfg_reg;
    tpu_pkg::result_t  result;
    logic              room;
    logic              step;

    assign step     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count <= tpu_pkg::CHANNEL_COUNT_RESET;
            cfg_reg.long_names    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tpu_pkg::CFG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data;
                tpu_pkg::CFG_LONG_NAMES:    cfg_reg.long_names    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    tpu_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    tpu_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .result    (result),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ hw/rtl/tpu_parser.sv @@
// Byte parser of the pattern unpacker: parse state registers and the one-byte step.
// Depends on tpu_pkg.
module tpu_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tpu_pkg::in_item_t item,
    input  tpu_pkg::cfg_t     cfg,
    output tpu_pkg::result_t  result
);

    tpu_pkg::phase_t    phase_reg, phase_next, phase_c, phase_step;
    logic [3:0]         hc_reg, hc_next, hc_c;
    logic [15:0]        rt_reg, rt_next, rt_c;
    logic [15:0]        rc_reg, rc_next, rc_c, rc_base;
    logic signed [16:0] rbl_reg, rbl_next, rbl_c;
    logic [3:0]         flags_reg, flags_next, flags_c;
    logic [7:0]         chan_reg, chan_next, chan_c;
    logic [7:0]         note_reg, note_next, note_c;
    logic [7:0]         ins_reg, ins_next, ins_c;
    logic [6:0]         vol_reg, vol_next, vol_c;
    logic [7:0]         fxt_reg, fxt_next, fxt_c;
    logic [7:0]         fxp_reg, fxp_next, fxp_c;

    logic        fin_req, end_direct, end_req, kept, last_row;
    logic [3:0]  pending;
    logic [16:0] rc_plus;
    logic [7:0]  b;
    tpu_pkg::fx_t fx;

    assign b = item.chunk_byte;

    // a start byte sees a freshly cleared parser
    always_comb
    begin
        phase_c = item.chunk_start ? tpu_pkg::PH_HDR : phase_reg;
        hc_c    = item.chunk_start ? 4'd0 : hc_reg;
        rt_c    = item.chunk_start ? 16'd0 : rt_reg;
        rc_c    = item.chunk_start ? 16'd0 : rc_reg;
        rbl_c   = item.chunk_start ? 17'sd0 : rbl_reg;
        flags_c = item.chunk_start ? 4'd0 : flags_reg;
        chan_c  = item.chunk_start ? 8'd0 : chan_reg;
        note_c  = item.chunk_start ? 8'd0 : note_reg;
        ins_c   = item.chunk_start ? 8'd0 : ins_reg;
        vol_c   = item.chunk_start ? 7'd0 : vol_reg;
        fxt_c   = item.chunk_start ? 8'd0 : fxt_reg;
        fxp_c   = item.chunk_start ? 8'd0 : fxp_reg;
    end

    assign fx = tpu_pkg::translate(fxt_c, b);

    // field updates and the plain phase step
    always_comb
    begin
        hc_next    = hc_c;
        rt_next    = rt_c;
        rc_base    = rc_c;
        rbl_next   = rbl_c;
        flags_next = flags_c;
        chan_next  = chan_c;
        note_next  = note_c;
        ins_next   = ins_c;
        vol_next   = vol_c;
        fxt_next   = fxt_c;
        fxp_next   = fxp_c;
        phase_step = phase_c;
        fin_req    = 1'b0;
        end_direct = 1'b0;
        pending    = 4'd0;
        case (phase_c)
            tpu_pkg::PH_HDR:
            begin
                hc_next = hc_c + 4'd1;
                if (hc_next >= (cfg.long_names ? tpu_pkg::HDR_LEN_LONG
                                               : tpu_pkg::HDR_LEN_SHORT))
                    phase_step = tpu_pkg::PH_ROWS_LO;
            end
            tpu_pkg::PH_ROWS_LO:
            begin
                rt_next    = {8'd0, b};
                phase_step = tpu_pkg::PH_ROWS_HI;
            end
            tpu_pkg::PH_ROWS_HI:
            begin
                rt_next    = {b, rt_c[7:0]};
                rc_base    = 16'd0;
                phase_step = tpu_pkg::PH_LEN_LO;
            end
            tpu_pkg::PH_LEN_LO:
            begin
                rbl_next   = $signed({9'd0, b});
                phase_step = tpu_pkg::PH_LEN_HI;
            end
            tpu_pkg::PH_LEN_HI:
            begin
                // length word counts itself
                rbl_next = $signed({1'b0, b, 8'd0}) + rbl_c - 17'sd2;
                if (rbl_next > 17'sd0)
                    phase_step = tpu_pkg::PH_FLAG;
                else
                    end_direct = 1'b1;
            end
            tpu_pkg::PH_FLAG:
            begin
                if (rbl_c == 17'sd1)
                    end_direct = 1'b1;
                else
                begin
                    flags_next = b[7:4];
                    chan_next  = 8'd0;
                    note_next  = 8'd0;
                    ins_next   = 8'd0;
                    vol_next   = 7'd0;
                    fxt_next   = 8'd0;
                    fxp_next   = 8'd0;
                    phase_step = tpu_pkg::PH_CHAN;
                end
            end
            tpu_pkg::PH_CHAN:
            begin
                chan_next = b;
                rbl_next  = rbl_c - 17'sd2;
                pending   = flags_c;
            end
            tpu_pkg::PH_NOTE:
            begin
                note_next = tpu_pkg::note_of(b);
                rbl_next  = rbl_c - 17'sd1;
                pending   = flags_c & 4'b0111;
            end
            tpu_pkg::PH_INS:
            begin
                ins_next = b + 8'd1;
                rbl_next = rbl_c - 17'sd1;
                pending  = flags_c & 4'b0011;
            end
            tpu_pkg::PH_VOL:
            begin
                vol_next = b[7:1];
                rbl_next = rbl_c - 17'sd1;
                pending  = flags_c & 4'b0001;
            end
            tpu_pkg::PH_FXT:
            begin
                fxt_next   = b;
                rbl_next   = rbl_c - 17'sd1;
                phase_step = tpu_pkg::PH_FXP;
            end
            tpu_pkg::PH_FXP:
            begin
                rbl_next = rbl_c - 17'sd1;
                if (fxt_c == tpu_pkg::FXI_LONG)
                begin
                    fxp_next   = b;
                    phase_step = tpu_pkg::PH_SKIP1;
                end
                else
                begin
                    fxt_next = fx.etype;
                    fxp_next = fx.eparam;
                    if (fx.set_note)
                    begin
                        note_next     = fx.note;
                        flags_next[3] = 1'b1;
                    end
                    fin_req = 1'b1;
                end
            end
            tpu_pkg::PH_SKIP1:
            begin
                rbl_next   = rbl_c - 17'sd1;
                phase_step = tpu_pkg::PH_SKIP2;
            end
            tpu_pkg::PH_SKIP2:
            begin
                rbl_next = rbl_c - 17'sd1;
                fin_req  = 1'b1;
            end
            default:
            begin
            end
        endcase

        // next field in the event, or the event is complete
        if (phase_c == tpu_pkg::PH_CHAN || phase_c == tpu_pkg::PH_NOTE ||
            phase_c == tpu_pkg::PH_INS || phase_c == tpu_pkg::PH_VOL)
        begin
            if (pending[3])
                phase_step = tpu_pkg::PH_NOTE;
            else if (pending[2])
                phase_step = tpu_pkg::PH_INS;
            else if (pending[1])
                phase_step = tpu_pkg::PH_VOL;
            else if (pending[0])
                phase_step = tpu_pkg::PH_FXT;
            else
                fin_req = 1'b1;
        end
    end

    // event completion and row end
    always_comb
    begin
        kept     = fin_req && (chan_next < cfg.channel_count) && (flags_next != 4'd0);
        end_req  = end_direct || (fin_req && !(rbl_next > 17'sd0));
        rc_plus  = {1'b0, rc_c} + 17'd1;
        last_row = rc_plus >= {1'b0, rt_next};
        if (end_req)
            phase_next = last_row ? tpu_pkg::PH_IDLE : tpu_pkg::PH_LEN_LO;
        else if (fin_req)
            phase_next = tpu_pkg::PH_FLAG;
        else
            phase_next = phase_step;
        rc_next = end_req ? rc_plus[15:0] : rc_base;
    end

    // result of this byte
    always_comb
    begin
        result.emit                  = kept || (end_req && last_row);
        result.item.row_index        = rc_c;
        result.item.pattern_done     = end_req && last_row;
        if (kept)
        begin
            result.item.channel_index    = chan_next;
            result.item.field_mask       = flags_next;
            result.item.note_value       = flags_next[3] ? note_next : 8'd0;
            result.item.instrument_value = flags_next[2] ? ins_next : 8'd0;
            result.item.volume_value     = flags_next[1] ? vol_next : 7'd0;
            result.item.effect_type      = flags_next[0] ? fxt_next : 8'd0;
            result.item.effect_param     = flags_next[0] ? fxp_next : 8'd0;
        end
        else
        begin
            result.item.channel_index    = 8'd0;
            result.item.field_mask       = 4'd0;
            result.item.note_value       = 8'd0;
            result.item.instrument_value = 8'd0;
            result.item.volume_value     = 7'd0;
            result.item.effect_type      = 8'd0;
            result.item.effect_param     = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tpu_pkg::PH_HDR;
            hc_reg    <= 4'd0;
            rt_reg    <= 16'd0;
            rc_reg    <= 16'd0;
            rbl_reg   <= 17'sd0;
            flags_reg <= 4'd0;
            chan_reg  <= 8'd0;
            note_reg  <= 8'd0;
            ins_reg   <= 8'd0;
            vol_reg   <= 7'd0;
            fxt_reg   <= 8'd0;
            fxp_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            rt_reg    <= rt_next;
            rc_reg    <= rc_next;
            rbl_reg   <= rbl_next;
            flags_reg <= flags_next;
            chan_reg  <= chan_next;
            note_reg  <= note_next;
            ins_reg   <= ins_next;
            vol_reg   <= vol_next;
            fxt_reg   <= fxt_next;
            fxp_reg   <= fxp_next;
        end
    end

endmodule

@@ hw/rtl/tpu_out_reg.sv @@
// Result register of the pattern unpacker: holds one result until the sink takes it.
// Depends on tpu_pkg.
module tpu_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  tpu_pkg::result_t   result,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output tpu_pkg::out_item_t out_data
);

    logic               valid_reg;
    tpu_pkg::out_item_t data_reg;

    // free now, or emptied at this edge
    assign room      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (step && result.emit)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && result.emit)
            data_reg <= result.item;
    end

endmodule

@@ hw/rtl/tpu_checker.sv @@
// Port-level checks of the pattern unpacker, bound to the top level.
// Depends on tpu_pkg and tracker_pattern_unpacker_defines.svh.
`include "tracker_pattern_unpacker_defines.svh"

module tpu_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input tpu_pkg::out_item_t                  out_data
);

    logic bare_out;
    logic bare_ok;

    assign bare_out = out_valid && (out_data.field_mask == 4'd0);
    assign bare_ok  = out_data.pattern_done && (out_data.channel_index == 8'd0)
                      && (out_data.note_value == 8'd0);

    `TPU_ASSERT_STALL(a_out_valid_holds, out_valid, out_ready, out_valid, "out_valid dropped")
    `TPU_ASSERT_STALL(a_out_data_holds, out_valid, out_ready, $stable(out_data), "data moved")
    // an empty result register never stalls the input side
    `TPU_ASSERT(a_in_ready_when_empty, !out_valid |-> in_ready, "input stalled, output empty")
    // a bare marker only ever closes the pattern
    `TPU_ASSERT(a_bare_marker, bare_out |-> bare_ok, "bare result is not a done marker")

endmodule

bind tracker_pattern_unpacker tpu_checker u_tpu_checker (.*);
